>>> design/rsps_pkg.sv
// Shared types, constants and width helpers for the ray-sphere pixel shader.
package rsps_pkg;

  localparam int COORD_FRAC_BITS_DEF  = 12;
  localparam int PIXEL_INDEX_BITS_DEF = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMG_COLS      = 3'd0,
    CFG_IMG_ROWS      = 3'd1,
    CFG_PIXEL_PITCH   = 3'd2,
    CFG_SPHERE_X      = 3'd3,
    CFG_SPHERE_Y      = 3'd4,
    CFG_SPHERE_Z      = 3'd5,
    CFG_SPHERE_RADIUS = 3'd6
  } cfg_reg_e;

  localparam logic [10:0] RST_IMG_COLS      = 11'd400;
  localparam logic [10:0] RST_IMG_ROWS      = 11'd225;
  localparam logic [15:0] RST_PIXEL_PITCH   = 16'd583;
  localparam logic [15:0] RST_SPHERE_X      = 16'h0000;
  localparam logic [15:0] RST_SPHERE_Y      = 16'h0000;
  localparam logic [15:0] RST_SPHERE_Z      = 16'hF000;
  localparam logic [14:0] RST_SPHERE_RADIUS = 15'd2048;

  localparam int YA_W    = 17;
  localparam int QUOT_W  = 17;
  localparam int COLOR_W = 8;

  localparam logic [17:0] A_ONE      = 18'd65536;
  localparam logic [18:0] RV_BASE    = 19'd262144;
  localparam logic [20:0] GV_BASE    = 21'd1310720;
  localparam logic [17:0] COLOR_MUL  = 18'd255999;
  localparam logic [18:0] RED_RECIP  = 19'd268436;
  localparam logic [22:0] GRN_RECIP  = 23'd6871948;

  typedef struct packed {
    logic [10:0] cols;
    logic [10:0] rows;
    logic [15:0] pixel_pitch;
  } view_t;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] sz;
    logic               s_neg;
    logic [31:0]        s_mag;
  } sph_t;

  typedef struct packed {
    logic            hit;
    logic            neg;
    logic [YA_W-1:0] ya;
  } side_t;

  typedef struct packed {
    logic               hit;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } pix_t;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // radicand width of |d|^2, rounded up to an even count
  function automatic int sq_width(input int frac);
    int w;
    w = max2(31, 2 * frac) + 2;
    return w + (w % 2);
  endfunction

endpackage

>>> design/rsps_ray.sv
// Ray direction: viewport offsets, pitch scaling, a flooring shift and saturation.
module rsps_ray #(
  parameter int COORD_FRAC_BITS  = rsps_pkg::COORD_FRAC_BITS_DEF,
  parameter int PIXEL_INDEX_BITS = rsps_pkg::PIXEL_INDEX_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [PIXEL_INDEX_BITS-1:0] col_i,
  input  logic [PIXEL_INDEX_BITS-1:0] row_i,
  input  rsps_pkg::view_t             view_i,
  output logic                        valid_o,
  output logic signed [15:0]          dx_o,
  output logic signed [15:0]          dy_o
);
  import rsps_pkg::*;

  localparam int VW = max2(PIXEL_INDEX_BITS + 1, 11) + 2;
  localparam int PW = VW + 17;
  localparam int WW = PW + 4;
  localparam int SR = (COORD_FRAC_BITS <= 17) ? 17 - COORD_FRAC_BITS : 0;
  localparam int SL = (COORD_FRAC_BITS > 17) ? COORD_FRAC_BITS - 17 : 0;
  localparam logic signed [WW-1:0] SAT_HI = WW'(32767);
  localparam logic signed [WW-1:0] SAT_LO = WW'(-32768);

  logic [2:0] v_q;
  logic signed [VW-1:0] vx_d, vy_d, vx_q, vy_q;
  logic signed [PW-1:0] mx_d, my_d, mx_q, my_q;
  logic signed [15:0]   dx_d, dy_d, dx_q, dy_q;

  function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
    logic signed [WW-1:0] s;
    s = (WW'(v) <<< SL) >>> SR;
    if (s > SAT_HI) return 16'sh7FFF;
    if (s < SAT_LO) return 16'sh8000;
    return s[15:0];
  endfunction

  always_comb begin
    vx_d = VW'({col_i, 1'b1}) - VW'(view_i.cols);
    vy_d = VW'(view_i.rows) - VW'({row_i, 1'b1});
    mx_d = PW'(vx_q) * PW'(signed'({1'b0, view_i.pixel_pitch}));
    my_d = PW'(vy_q) * PW'(signed'({1'b0, view_i.pixel_pitch}));
    dx_d = sat16(mx_q);
    dy_d = sat16(my_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vx_q <= vx_d;
      vy_q <= vy_d;
      mx_q <= mx_d;
      my_q <= my_d;
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  assign valid_o = v_q[2];
  assign dx_o    = dx_q;
  assign dy_o    = dy_q;

endmodule

>>> design/rsps_hit.sv
// Sphere test: |d|^2, d.c and the exact discriminant compare over split products.
module rsps_hit #(
  parameter int COORD_FRAC_BITS = rsps_pkg::COORD_FRAC_BITS_DEF,
  parameter int QW              = rsps_pkg::sq_width(rsps_pkg::COORD_FRAC_BITS_DEF)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [15:0] dx_i,
  input  logic signed [15:0] dy_i,
  input  rsps_pkg::sph_t     sph_i,
  output logic               valid_o,
  output logic [QW-1:0]      q_o,
  output rsps_pkg::side_t    side_o
);
  import rsps_pkg::*;

  localparam int PW2 = max2(32, 16 + COORD_FRAC_BITS) + 2;
  localparam int AW  = max2(PW2, 33);
  localparam int HW  = AW - 32;
  localparam int QH  = QW - 32;
  localparam int CW  = max2(2 * AW, QW + 32) + 1;

  logic [5:0] v_q;
  side_t side_d, side_q [6];
  logic [QW-1:0] q_d, q_q [5];

  logic signed [31:0]    xx_q, yy_q, xs_q, ys_q;
  logic signed [PW2-1:0] zs_q, p_d, p_q;
  logic [AW-1:0]         pa_d, pa_q;
  logic [63:0]           mll_q, nl_q;
  logic [31+HW:0]        mlh_q;
  logic [2*HW-1:0]       mhh_q;
  logic [QH+31:0]        nh_q;
  logic [CW-1:0]         lhs_d, rhs_d, lhs_q, rhs_q;
  logic signed [16:0]    dye;

  always_comb begin
    dye       = 17'(dy_i);
    side_d.hit = 1'b0;
    side_d.neg = dye[16];
    side_d.ya  = dye[16] ? YA_W'(-dye) : YA_W'(dye);
    q_d  = QW'(xx_q) + QW'(yy_q) + (QW'(1) << (2 * COORD_FRAC_BITS));
    p_d  = PW2'(xs_q) + PW2'(ys_q) - zs_q;
    pa_d = p_q[PW2-1] ? AW'(-p_q) : AW'(p_q);
    lhs_d = (CW'(mhh_q) << 64) + (CW'(mlh_q) << 33) + CW'(mll_q);
    rhs_d = (CW'(nh_q) << 32) + CW'(nl_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= 32'(dx_i) * 32'(dx_i);
      yy_q <= 32'(dy_i) * 32'(dy_i);
      xs_q <= 32'(dx_i) * 32'(sph_i.sx);
      ys_q <= 32'(dy_i) * 32'(sph_i.sy);
      zs_q <= PW2'(sph_i.sz) <<< COORD_FRAC_BITS;
      side_q[0] <= side_d;
      q_q[0] <= q_d;
      p_q <= p_d;
      side_q[1] <= side_q[0];
      q_q[1] <= q_q[0];
      pa_q <= pa_d;
      side_q[2] <= side_q[1];
      q_q[2] <= q_q[1];
      mll_q <= 64'(pa_q[31:0]) * 64'(pa_q[31:0]);
      mlh_q <= (32 + HW)'(pa_q[31:0]) * (32 + HW)'(pa_q[AW-1:32]);
      mhh_q <= (2 * HW)'(pa_q[AW-1:32]) * (2 * HW)'(pa_q[AW-1:32]);
      nl_q  <= 64'(q_q[1][31:0]) * 64'(sph_i.s_mag);
      nh_q  <= (QH + 32)'(q_q[1][QW-1:32]) * (QH + 32)'(sph_i.s_mag);
      side_q[3] <= side_q[2];
      q_q[3] <= q_q[2];
      lhs_q <= lhs_d;
      rhs_q <= rhs_d;
      side_q[4] <= side_q[3];
      q_q[4] <= q_q[3];
      side_q[5].hit <= sph_i.s_neg || (lhs_q >= rhs_q);
      side_q[5].neg <= side_q[4].neg;
      side_q[5].ya  <= side_q[4].ya;
    end
  end

  assign valid_o = v_q[5];
  assign q_o     = q_q[4];
  assign side_o  = side_q[5];

endmodule

>>> design/rsps_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module rsps_isqrt #(
  parameter int QW = rsps_pkg::sq_width(rsps_pkg::COORD_FRAC_BITS_DEF)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [QW-1:0]     q_i,
  input  rsps_pkg::side_t   side_i,
  output logic              valid_o,
  output logic [QW/2-1:0]   root_o,
  output rsps_pkg::side_t   side_o
);
  import rsps_pkg::*;

  localparam int NS = QW / 2;

  logic [NS-1:0] v_q;
  logic [QW-1:0] rad_p [NS], rad_d [NS], rad_q [NS];
  logic [NS-1:0] rem_p [NS], rem_d [NS], rem_q [NS];
  logic [NS-1:0] root_p [NS], root_d [NS], root_q [NS];
  side_t         side_p [NS], side_q [NS];
  logic [NS+1:0] remsh [NS], trial [NS];

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        rad_p[k]  = q_i;
        rem_p[k]  = '0;
        root_p[k] = '0;
        side_p[k] = side_i;
      end else begin
        rad_p[k]  = rad_q[k-1];
        rem_p[k]  = rem_q[k-1];
        root_p[k] = root_q[k-1];
        side_p[k] = side_q[k-1];
      end
      remsh[k] = {rem_p[k], rad_p[k][QW-1 -: 2]};
      trial[k] = {root_p[k], 2'b01};
      rad_d[k] = rad_p[k] << 2;
      if (remsh[k] >= trial[k]) begin
        rem_d[k]  = NS'(remsh[k] - trial[k]);
        root_d[k] = {root_p[k][NS-2:0], 1'b1};
      end else begin
        rem_d[k]  = NS'(remsh[k]);
        root_d[k] = {root_p[k][NS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        rad_q[k]  <= rad_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        side_q[k] <= side_p[k];
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

>>> design/rsps_div.sv
// Pipelined restoring divider: |y| * 2^16 / |d|, one quotient bit per stage.
module rsps_div #(
  parameter int NS = rsps_pkg::sq_width(rsps_pkg::COORD_FRAC_BITS_DEF) / 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [NS-1:0]               root_i,
  input  rsps_pkg::side_t             side_i,
  output logic                        valid_o,
  output logic [rsps_pkg::QUOT_W-1:0] quot_o,
  output rsps_pkg::side_t             side_o
);
  import rsps_pkg::*;

  logic [QUOT_W-1:0] v_q;
  logic [NS-1:0]     r_p [QUOT_W], r_q [QUOT_W];
  logic [NS-1:0]     rem_p [QUOT_W], rem_d [QUOT_W], rem_q [QUOT_W];
  logic [QUOT_W-1:0] quot_p [QUOT_W], quot_d [QUOT_W], quot_q [QUOT_W];
  side_t             side_p [QUOT_W], side_q [QUOT_W];
  logic              bit_p [QUOT_W];
  logic [NS:0]       remsh [QUOT_W];

  always_comb begin
    for (int k = 0; k < QUOT_W; k++) begin
      if (k == 0) begin
        r_p[k]    = root_i;
        rem_p[k]  = NS'(side_i.ya >> 1);
        quot_p[k] = '0;
        side_p[k] = side_i;
        bit_p[k]  = side_i.ya[0];
      end else begin
        r_p[k]    = r_q[k-1];
        rem_p[k]  = rem_q[k-1];
        quot_p[k] = quot_q[k-1];
        side_p[k] = side_q[k-1];
        bit_p[k]  = 1'b0;
      end
      remsh[k] = {rem_p[k], bit_p[k]};
      if (remsh[k] >= {1'b0, r_p[k]}) begin
        rem_d[k]  = NS'(remsh[k] - {1'b0, r_p[k]});
        quot_d[k] = {quot_p[k][QUOT_W-2:0], 1'b1};
      end else begin
        rem_d[k]  = NS'(remsh[k]);
        quot_d[k] = {quot_p[k][QUOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QUOT_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QUOT_W; k++) begin
        r_q[k]    <= r_p[k];
        rem_q[k]  <= rem_d[k];
        quot_q[k] <= quot_d[k];
        side_q[k] <= side_p[k];
      end
    end
  end

  assign valid_o = v_q[QUOT_W-1];
  assign quot_o  = quot_q[QUOT_W-1];
  assign side_o  = side_q[QUOT_W-1];

endmodule

>>> design/rsps_shade.sv
// Sky gradient and hit color, then a two-entry output queue.
module rsps_shade (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [rsps_pkg::QUOT_W-1:0] quot_i,
  input  rsps_pkg::side_t             side_i,
  output logic                        en_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output rsps_pkg::pix_t              pix_o
);
  import rsps_pkg::*;

  logic [3:0]  v_q;
  logic [3:0]  hit_q;
  logic [17:0] a17_d, a17_q;
  logic [18:0] rv_q;
  logic [20:0] gv_q;
  logic [36:0] rp_q;
  logic [38:0] gp_q;
  logic [37:0] rm_q;
  logic [44:0] gm_q;
  pix_t        pix_d;
  pix_t        mem_q [2];
  logic        wp_q, rp_ptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  always_comb begin
    a17_d = side_i.neg ? (A_ONE - 18'(quot_i)) : (A_ONE + 18'(quot_i));
    pix_d.hit   = hit_q[3];
    pix_d.red   = hit_q[3] ? {COLOR_W{1'b1}} : rm_q[35:28];
    pix_d.green = hit_q[3] ? '0 : gm_q[43:36];
    pix_d.blue  = hit_q[3] ? '0 : {COLOR_W{1'b1}};
  end

  assign en_o = (cnt_q != 2'd2);
  assign push = en_o && v_q[3];
  assign pop  = (cnt_q != 2'd0) && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= '0;
      wp_q     <= 1'b0;
      rp_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (en_o) v_q <= {v_q[2:0], valid_i};
      if (push) wp_q <= ~wp_q;
      if (pop) rp_ptr_q <= ~rp_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      hit_q <= {hit_q[2:0], side_i.hit};
      a17_q <= a17_d;
      rv_q  <= RV_BASE - 19'(a17_q);
      gv_q  <= GV_BASE - 21'(a17_q) - 21'({a17_q, 1'b0});
      rp_q  <= 37'(rv_q) * 37'(COLOR_MUL);
      gp_q  <= 39'(gv_q) * 39'(COLOR_MUL);
      rm_q  <= 38'(rp_q[36:18]) * 38'(RED_RECIP);
      gm_q  <= 45'(gp_q[38:17]) * 45'(GRN_RECIP);
    end
    if (push) mem_q[wp_q] <= pix_d;
  end

  assign valid_o = (cnt_q != 2'd0);
  assign pix_o   = mem_q[rp_ptr_q];

endmodule

>>> design/ray_sphere_pixel_shader_core.sv
// Top level of the ray-sphere pixel shader: ports, registers and pipeline chain.
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tdata: pixel_col, pixel_row
//  m_axis    out        m_axis_tvalid/tready      tdata: red, green, blue; tuser: sphere_hit
//  cfg       in         cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// One pixel per clock while the output queue has room; QW = sq_width(frac bits).
// Chain: ray, sphere test, square root, divider, shade. Reset loads register defaults;
// a write rebuilds the discriminant constant in its square and then its sum registers.
// A two-entry output queue decouples the sides; the pipeline holds only when it is full.
module ray_sphere_pixel_shader_core #(
  parameter int COORD_FRAC_BITS  = rsps_pkg::COORD_FRAC_BITS_DEF,
  parameter int PIXEL_INDEX_BITS = rsps_pkg::PIXEL_INDEX_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((2*PIXEL_INDEX_BITS+7)/8)*8-1:0] s_axis_tdata, // pixel_col, pixel_row
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata,  // red, green, blue
  output logic                              m_axis_tuser,  // sphere_hit
  input  logic                              cfg_we_i,
  input  logic [rsps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rsps_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import rsps_pkg::*;

  localparam int QW = sq_width(COORD_FRAC_BITS);
  localparam int NS = QW / 2;

  logic [10:0]        img_cols_q, img_rows_q;
  logic [15:0]        pixel_pitch_q;
  logic signed [15:0] sphere_x_q, sphere_y_q, sphere_z_q;
  logic [14:0]        sphere_radius_q;

  logic signed [31:0] sxx_q, syy_q, szz_q;
  logic [29:0]        rr_q;
  logic signed [33:0] s_q;

  view_t view;
  sph_t  sph;
  logic  en;

  logic               ray_v, hit_v, sqrt_v, div_v, out_v;
  logic signed [15:0] dx, dy;
  logic [QW-1:0]      q;
  side_t              hit_side, sqrt_side, div_side;
  logic [NS-1:0]      root;
  logic [QUOT_W-1:0]  quot;
  pix_t               pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_cols_q      <= RST_IMG_COLS;
      img_rows_q      <= RST_IMG_ROWS;
      pixel_pitch_q   <= RST_PIXEL_PITCH;
      sphere_x_q      <= RST_SPHERE_X;
      sphere_y_q      <= RST_SPHERE_Y;
      sphere_z_q      <= RST_SPHERE_Z;
      sphere_radius_q <= RST_SPHERE_RADIUS;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_IMG_COLS:      img_cols_q      <= cfg_data_i[10:0];
        CFG_IMG_ROWS:      img_rows_q      <= cfg_data_i[10:0];
        CFG_PIXEL_PITCH:   pixel_pitch_q   <= cfg_data_i;
        CFG_SPHERE_X:      sphere_x_q      <= cfg_data_i;
        CFG_SPHERE_Y:      sphere_y_q      <= cfg_data_i;
        CFG_SPHERE_Z:      sphere_z_q      <= cfg_data_i;
        CFG_SPHERE_RADIUS: sphere_radius_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    sxx_q <= 32'(sphere_x_q) * 32'(sphere_x_q);
    syy_q <= 32'(sphere_y_q) * 32'(sphere_y_q);
    szz_q <= 32'(sphere_z_q) * 32'(sphere_z_q);
    rr_q  <= 30'(sphere_radius_q) * 30'(sphere_radius_q);
    s_q   <= 34'(sxx_q) + 34'(syy_q) + 34'(szz_q) - 34'(rr_q);
  end

  always_comb begin
    view.cols        = img_cols_q;
    view.rows        = img_rows_q;
    view.pixel_pitch = pixel_pitch_q;
    sph.sx    = sphere_x_q;
    sph.sy    = sphere_y_q;
    sph.sz    = sphere_z_q;
    sph.s_neg = s_q[33];
    sph.s_mag = s_q[31:0];
  end

  assign s_axis_tready = en;

  rsps_ray #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .PIXEL_INDEX_BITS(PIXEL_INDEX_BITS)
  ) u_ray (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s_axis_tvalid),
    .col_i  (s_axis_tdata[PIXEL_INDEX_BITS-1:0]),
    .row_i  (s_axis_tdata[2*PIXEL_INDEX_BITS-1:PIXEL_INDEX_BITS]),
    .view_i (view),
    .valid_o(ray_v),
    .dx_o   (dx),
    .dy_o   (dy)
  );

  rsps_hit #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .QW             (QW)
  ) u_hit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(ray_v),
    .dx_i   (dx),
    .dy_i   (dy),
    .sph_i  (sph),
    .valid_o(hit_v),
    .q_o    (q),
    .side_o (hit_side)
  );

  rsps_isqrt #(
    .QW(QW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(hit_v),
    .q_i    (q),
    .side_i (hit_side),
    .valid_o(sqrt_v),
    .root_o (root),
    .side_o (sqrt_side)
  );

  rsps_div #(
    .NS(NS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(sqrt_v),
    .root_i (root),
    .side_i (sqrt_side),
    .valid_o(div_v),
    .quot_o (quot),
    .side_o (div_side)
  );

  rsps_shade u_shade (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(div_v),
    .quot_i (quot),
    .side_i (div_side),
    .en_o   (en),
    .valid_o(out_v),
    .ready_i(m_axis_tready),
    .pix_o  (pix)
  );

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {pix.blue, pix.green, pix.red};
  assign m_axis_tuser  = pix.hit;

endmodule

>>> tb/ray_sphere_pixel_shader_core_test.sv
// Self-checking stream testbench for the ray-sphere pixel shader core.
`timescale 1ns / 1ps

module ray_sphere_pixel_shader_core_test;
  import rsps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [9:0] col;
    logic [9:0] row;
  } pixel_req_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       hit;
  } pixel_color_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ray_sphere_pixel_shader_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  // shadow of the register file
  logic [10:0]        img_w = RST_IMG_COLS;
  logic [10:0]        img_h = RST_IMG_ROWS;
  logic [15:0]        pitch = RST_PIXEL_PITCH;
  logic signed [15:0] ctr_x = RST_SPHERE_X;
  logic signed [15:0] ctr_y = RST_SPHERE_Y;
  logic signed [15:0] ctr_z = RST_SPHERE_Z;
  logic [14:0]        radius = RST_SPHERE_RADIUS;

  pixel_req_t   pixels_pending[$];
  pixel_color_t colors_due[$];
  int  errors = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  quiet_cycles = 0;
  bit  send_hold = 1'b0;

  function automatic int rand_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic longint floor_coord(longint v);
    longint q;
    q = v >>> (17 - COORD_FRAC_BITS_DEF);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic pixel_color_t shade_pixel(pixel_req_t px);
    pixel_color_t c;
    longint dx, dy, dz, p, s, sx, sy, sz, sr, u, a17;
    longint unsigned q, pa, r, ya, rv, gv;
    logic [127:0] pp, qs;
    sx = ctr_x; sy = ctr_y; sz = ctr_z; sr = radius;
    dx = floor_coord((2 * longint'(px.col) + 1 - longint'(img_w)) * longint'(pitch));
    dy = floor_coord((longint'(img_h) - 2 * longint'(px.row) - 1) * longint'(pitch));
    dz = -(longint'(1) << COORD_FRAC_BITS_DEF);
    q = dx * dx + dy * dy + dz * dz;
    p = dx * sx + dy * sy + dz * sz;
    s = sx * sx + sy * sy + sz * sz - sr * sr;
    if (s < 0) begin
      c.hit = 1'b1;
    end else begin
      pa = (p < 0) ? -p : p;
      pp = {64'd0, pa} * {64'd0, pa};
      qs = {64'd0, q} * {64'd0, 64'(s)};
      c.hit = (pp >= qs);
    end
    if (c.hit) begin
      c.red = 8'd255; c.green = 8'd0; c.blue = 8'd0;
      return c;
    end
    r = int_sqrt(q);
    ya = (dy < 0) ? -dy : dy;
    u = longint'((ya << 16) / r);
    if (dy < 0) u = -u;
    a17 = u + 65536;
    rv = (longint'(1) << 18) - a17;
    gv = 10 * (longint'(1) << 17) - 3 * a17;
    c.red = 8'((rv * 255999) / (1000 * (64'd1 << 18)));
    c.green = 8'((gv * 255999) / (10000 * (64'd1 << 17)));
    c.blue = 8'd255;
    return c;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_IMG_COLS:      img_w = val[10:0];
      CFG_IMG_ROWS:      img_h = val[10:0];
      CFG_PIXEL_PITCH:   pitch = val;
      CFG_SPHERE_X:      ctr_x = val;
      CFG_SPHERE_Y:      ctr_y = val;
      CFG_SPHERE_Z:      ctr_z = val;
      CFG_SPHERE_RADIUS: radius = val[14:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_view(int w, int h, int pt, int sx, int sy, int sz, int rad);
    write_reg(CFG_IMG_COLS, 16'(w));
    write_reg(CFG_IMG_ROWS, 16'(h));
    write_reg(CFG_PIXEL_PITCH, 16'(pt));
    write_reg(CFG_SPHERE_X, 16'(sx));
    write_reg(CFG_SPHERE_Y, 16'(sy));
    write_reg(CFG_SPHERE_Z, 16'(sz));
    write_reg(CFG_SPHERE_RADIUS, 16'(rad));
    // let the discriminant constant settle
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_pixel(int col, int row);
    pixel_req_t px;
    px.col = 10'(col);
    px.row = 10'(row);
    pixels_pending.push_back(px);
  endtask

  task automatic wait_idle();
    while (pixels_pending.size() != 0 || colors_due.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
  endtask

  task automatic queue_random(int count);
    int w, h;
    w = (img_w == 0) ? 1 : img_w;
    h = (img_h == 0) ? 1 : img_h;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8)
        push_pixel($urandom_range(0, (w > 1024 ? 1024 : w) - 1),
                   $urandom_range(0, (h > 1024 ? 1024 : h) - 1));
      else
        push_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid && s_axis_tready)
        colors_due.push_back(shade_pixel(pixels_pending.pop_front()));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pixels_pending.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0)
                   && !send_hold && rst_ni) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, pixels_pending[0].row, pixels_pending[0].col};
        send_gap <= rand_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pixel_color_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (colors_due.size() == 0) begin
        $error("unexpected pixel: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = colors_due.pop_front();
        if (m_axis_tdata[7:0] !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[15:8] !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, m_axis_tdata[15:8]);
          errors++;
        end
        if (m_axis_tdata[23:16] !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, m_axis_tdata[23:16]);
          errors++;
        end
        if (m_axis_tuser !== want.hit) begin
          $error("sphere_hit: expected %0d, got %0d", want.hit, m_axis_tuser);
          errors++;
        end
      end
    end
    if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
      recv_gap <= rand_gap();
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ray_sphere_pixel_shader_core_test: FAIL");
      $finish;
    end
  end

  initial begin
    int h;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: corners, centre, sphere edge, out of image
    push_pixel(0, 0);       push_pixel(399, 224);  push_pixel(200, 112);
    push_pixel(199, 112);   push_pixel(200, 56);   push_pixel(0, 224);
    push_pixel(399, 0);     push_pixel(1023, 1023); push_pixel(1023, 0);
    push_pixel(0, 1023);    push_pixel(512, 511);  push_pixel(682, 341);
    wait_idle();

    // zero pitch, sphere behind camera, unknown index ignored
    set_view(400, 225, 0, 0, 0, 4096, 2048);
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    push_pixel(0, 0); push_pixel(1023, 1023);
    wait_idle();
    // saturating coordinates, zero radius, grazing hit
    set_view(1, 1024, 65535, -32768, 32767, -32768, 0);
    push_pixel(1023, 0); push_pixel(0, 1023); push_pixel(0, 512);
    wait_idle();
    set_view(1024, 1, 65535, 32767, -32768, 32767, 32767);
    push_pixel(1023, 0); push_pixel(0, 0); push_pixel(511, 0);
    wait_idle();
    set_view(2, 2, 65535, 0, 0, -4096, 4096);
    push_pixel(0, 0); push_pixel(1, 1); push_pixel(1, 0);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      h = $urandom_range(1, 1024);
      if (ph % 4 == 3)
        set_view($urandom_range(1, 1024), h, $urandom_range(0, 65535),
                 $signed(16'($urandom)), $signed(16'($urandom)),
                 $signed(16'($urandom)), $urandom_range(0, 32767));
      else
        set_view($urandom_range(1, 1024), h, 131072 / h + $urandom_range(0, 3),
                 $urandom_range(0, 2048) - 1024, $urandom_range(0, 2048) - 1024,
                 -$urandom_range(2048, 12288), $urandom_range(512, 6144));
      queue_random(90);
      if (ph == 4) begin
        send_hold = 1'b1;
        while (colors_due.size() != 0 || s_axis_tvalid) @(posedge clk_i);
        send_hold = 1'b0;
      end
      queue_random(90);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && colors_due.size() == 0)
      $display("ray_sphere_pixel_shader_core_test: PASS");
    else
      $display("ray_sphere_pixel_shader_core_test: FAIL");
    $finish;
  end

endmodule
